>>> rtl/text_glyph_renderer_unit_defines.svh
`ifndef TEXT_GLYPH_RENDERER_UNIT_DEFINES_SVH
`define TEXT_GLYPH_RENDERER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TGR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph renderer check failed");

// next-cycle implication, sampled on clk, off during reset
`define TGR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph renderer check failed");

`endif

>>> rtl/tgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_ROWS  = 16;
	localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
	localparam int ROW_W       = $clog2(GLYPH_ROWS);
	localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW     = GLYPH_W + ROW_W;
	localparam int COORD_W     = 12;
	localparam int COORD_MAX   = 4095;
	localparam int LW_W        = 13;
	localparam int ADDR_W      = 32;
	localparam int PIX_W       = 64;
	localparam int CHAR_W      = 8;
	localparam int GROW_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int PROD_W      = COORD_W + LW_W;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_DRAW  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_LINE_WIDTH   = 2'd1,
		REG_FORE_COLOUR  = 2'd2,
		REG_BACK_COLOUR  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MULT,
		ST_BASE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [LW_W-1:0]   line_width;
		logic [7:0]        fore_colour;
		logic [7:0]        back_colour;
	} cfg_t;

	function automatic logic [PIX_W-1:0] expand_row(
		input logic [7:0] bits,
		input logic [7:0] fore,
		input logic [7:0] back
	);
		logic [PIX_W-1:0] pix;
		pix = '0;
		for (int n = 0; n < 8; n++) begin
			pix[8*n +: 8] = bits[7-n] ? fore : back;
		end
		return pix;
	endfunction

endpackage

`default_nettype wire

>>> rtl/text_glyph_renderer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tuser: opcode; tdata: char_code, glyph_row, row_bits, pos_x, pos_y
// m_*      out  tdata: row_address, row_pixels; tlast: last_row
// cfg_*    in   index 0 base_address, 1 line_width, 2 fore_colour, 3 back_colour
//
// Load and start words are taken while idle and leave the unit idle. A draw
// word first forms cursor y times line width, then adds base and x, and then
// does one font store read per glyph row for all 16 rows; s_tready is low
// until the last row is read. Output stalls hold the read stage and stop
// further font reads. arst_n clears the cursor and the handshake state and sets
// the config registers to their defaults; the font store is not cleared.

`include "text_glyph_renderer_unit_defines.svh"

module text_glyph_renderer_unit import tgr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [47:0]           s_tdata,  // char_code, glyph_row, row_bits, pos_x, pos_y
	input  wire logic [1:0]            s_tuser,  // opcode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [95:0]                m_tdata,  // row_address, row_pixels
	output logic                       m_tlast
);

	cfg_t                cfg_q;
	opcode_t             in_op;
	logic [CHAR_W-1:0]   in_char;
	logic [GROW_W-1:0]   in_grow;
	logic [7:0]          in_bits;
	logic [COORD_W-1:0]  in_x, in_y;

	logic                ram_we;
	logic [FONT_AW-1:0]  ram_waddr;
	logic                rd_en;
	logic [FONT_AW-1:0]  rd_addr;
	logic [7:0]          rd_data;
	logic [ADDR_W-1:0]   out_addr;
	logic [PIX_W-1:0]    out_pix;

	assign in_op   = opcode_t'(s_tuser);
	assign in_char = s_tdata[7:0];
	assign in_grow = s_tdata[11:8];
	assign in_bits = s_tdata[19:12];
	assign in_x    = s_tdata[31:20];
	assign in_y    = s_tdata[43:32];

	assign ram_we    = s_tvalid && s_tready && in_op == OP_LOAD
		&& (32'(in_grow) < GLYPH_ROWS);
	assign ram_waddr = {in_char[GLYPH_W-1:0], in_grow[ROW_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= '0;
			cfg_q.line_width   <= LW_W'(320);
			cfg_q.fore_colour  <= 8'd15;
			cfg_q.back_colour  <= 8'd0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data[ADDR_W-1:0];
				REG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data[LW_W-1:0];
				REG_FORE_COLOUR:  cfg_q.fore_colour  <= cfg_data[7:0];
				REG_BACK_COLOUR:  cfg_q.back_colour  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tgr_ram #(
		.WIDTH(8),
		.DEPTH(FONT_DEPTH)
	) u_font (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_bits),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tgr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (in_op),
		.in_glyph  (in_char[GLYPH_W-1:0]),
		.in_x      (in_x),
		.in_y      (in_y),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (out_addr),
		.out_pix   (out_pix),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_pix, out_addr};

	`TGR_ASSERT_NOW(a_no_read_when_ready, rd_en, !s_tready)
	`TGR_ASSERT_NOW(a_write_only_idle, ram_we, s_tready && !rd_en)
	`TGR_ASSERT_NEXT(a_idle_after_last_read,
		rd_en && (rd_addr[ROW_W-1:0] == ROW_W'(GLYPH_ROWS - 1)), s_tready)

endmodule

`default_nettype wire

>>> rtl/tgr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/tgr_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tgr_seq import tgr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire opcode_t            in_op,
	input  wire logic [GLYPH_W-1:0] in_glyph,
	input  wire logic [COORD_W-1:0] in_x,
	input  wire logic [COORD_W-1:0] in_y,
	output logic                    rd_en,
	output logic [FONT_AW-1:0]      rd_addr,
	input  wire logic [7:0]         rd_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [ADDR_W-1:0]       out_addr,
	output logic [PIX_W-1:0]        out_pix,
	output logic                    out_last
);

	state_t              state_q, state_d;
	logic [COORD_W-1:0]  cur_x_q, cur_y_q;
	logic [GLYPH_W-1:0]  glyph_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_W-1:0]   row_addr_q;
	logic [ROW_W-1:0]    row_q;
	logic                row_last;
	logic                accept;

	logic                valid_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                last_s1;
	logic                take_s1;

	logic [LW_W-1:0]     next_x;
	logic [LW_W-1:0]     next_y;
	logic                wrap;

	assign accept   = in_valid && in_ready;
	assign row_last = (row_q == ROW_W'(GLYPH_ROWS - 1));
	assign rd_addr  = {glyph_q, row_q};
	assign take_s1  = valid_s1 && (!out_valid || out_ready);

	assign next_x = LW_W'(cur_x_q) + LW_W'(8);
	assign next_y = LW_W'(cur_y_q) + LW_W'(GLYPH_ROWS);
	assign wrap   = (next_x >= cfg.line_width) || (next_x > LW_W'(COORD_MAX));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_op == OP_DRAW) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT: state_d = ST_BASE;
			ST_BASE: state_d = ST_RUN;
			ST_RUN: begin
				if (rd_en && row_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MULT, ST_BASE: ;
			ST_RUN:  rd_en = !valid_s1 || take_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && in_op == OP_START) begin
				cur_x_q <= in_x;
				cur_y_q <= in_y;
			end else if (rd_en && row_last) begin
				if (wrap) begin
					cur_x_q <= '0;
					cur_y_q <= (next_y > LW_W'(COORD_MAX)) ? COORD_W'(COORD_MAX)
						: next_y[COORD_W-1:0];
				end else begin
					cur_x_q <= next_x[COORD_W-1:0];
				end
			end
		end
	end

	// glyph row address walks down by one line stride per row
	always_ff @(posedge clk) begin
		if (accept && in_op == OP_DRAW) begin
			glyph_q <= in_glyph;
		end
		if (state_q == ST_MULT) begin
			prod_q <= PROD_W'(cur_y_q * cfg.line_width);
		end
		if (state_q == ST_BASE) begin
			row_addr_q <= cfg.base_address + ADDR_W'(prod_q) + ADDR_W'(cur_x_q);
			row_q      <= '0;
		end else if (rd_en) begin
			row_addr_q <= row_addr_q + ADDR_W'(cfg.line_width);
			row_q      <= row_q + ROW_W'(1);
		end
	end

	// read data stays on the RAM port until the output register takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= row_addr_q;
			last_s1 <= row_last;
		end
		if (take_s1) begin
			out_addr <= addr_s1;
			out_last <= last_s1;
			out_pix  <= expand_row(rd_data, cfg.fore_colour, cfg.back_colour);
		end
	end

endmodule

`default_nettype wire
